/* src/drct_pkg.sv */
`default_nettype none

package drct_pkg;

  // Default table depth
  localparam int unsigned MAX_ENTRIES_DEF = 16;

  // FNV-1a 32-bit constants
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 120;
  localparam int unsigned MASK_W     = 16;

  // Operation codes carried in tuser
  typedef enum logic [2:0] {
    OP_REGISTER    = 3'd0,
    OP_CONTENT     = 3'd1,
    OP_MARK_DIRTY  = 3'd2,
    OP_MARK_ALL    = 3'd3,
    OP_MARK_CLEAN  = 3'd4,
    OP_RESET_STATS = 3'd5
  } op_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_SCAN,
    ST_FINISH,
    ST_EMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic hash_step;
    logic scan_run;
    logic finish;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* src/drct_ctrl.sv */
`default_nettype none

module drct_ctrl (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  input  wire logic [drct_pkg::IN_USER_W-1:0]   in_op_i,
  input  wire drct_pkg::sts_t                   sts_i,
  output drct_pkg::cmd_t                        cmd_o
);

  drct_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= drct_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      drct_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          case (in_op_i) inside
            drct_pkg::OP_CONTENT: state_d = drct_pkg::ST_HASH;
            drct_pkg::OP_REGISTER, drct_pkg::OP_MARK_DIRTY, drct_pkg::OP_MARK_ALL,
            drct_pkg::OP_MARK_CLEAN, drct_pkg::OP_RESET_STATS: state_d = drct_pkg::ST_SCAN;
            default: state_d = drct_pkg::ST_IDLE;
          endcase
        end
      end
      drct_pkg::ST_HASH: begin
        cmd_o.hash_step = 1'b1;
        state_d = sts_i.last ? drct_pkg::ST_SCAN : drct_pkg::ST_IDLE;
      end
      drct_pkg::ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_done) begin
          state_d = drct_pkg::ST_FINISH;
        end
      end
      drct_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = drct_pkg::ST_EMIT;
      end
      drct_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = drct_pkg::ST_IDLE;
        end
      end
      default: state_d = drct_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* src/drct_datapath.sv */
`default_nettype none

module drct_datapath #(
  parameter int unsigned MAX_ENTRIES = drct_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire drct_pkg::cmd_t                   cmd_i,
  output drct_pkg::sts_t                        sts_o,
  input  wire logic                             in_valid_i,
  input  wire logic [drct_pkg::IN_DATA_W-1:0]   in_data_i,
  input  wire logic [drct_pkg::IN_USER_W-1:0]   in_op_i,
  input  wire logic                             in_last_i,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output logic [drct_pkg::OUT_DATA_W-1:0]       out_data_o
);

  localparam int unsigned PW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned MW = drct_pkg::MASK_W;

  // Captured request
  logic [2:0]  op_q;
  logic [7:0]  rid_q;
  logic [7:0]  byte_q;
  logic        bvalid_q;
  logic        last_q;

  // Table storage
  logic [7:0]             ids_mem  [MAX_ENTRIES];
  logic [31:0]            hash_mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] dirty_q;
  logic [PW-1:0]          count_q;

  // Scan state
  logic [PW-1:0] ptr_q;
  logic          cmp_v_q;
  logic [IW-1:0] cmp_idx_q;
  logic [7:0]    id_rd_q;
  logic [31:0]   hash_rd_q;
  logic          found_q;
  logic [IW-1:0] slot_q;
  logic          chg_q;
  logic [MW-1:0] mask_q;
  logic          any_q;
  logic          changed_q;

  // Hash and statistics
  logic [31:0] rh_q;
  logic [31:0] checks_q;
  logic [31:0] updates_q;
  logic [31:0] skips_q;

  // Output register
  logic                              out_valid_q;
  logic [drct_pkg::OUT_DATA_W-1:0]   out_data_q;

  logic          load;
  logic          issue;
  logic          match;
  logic          old_dirty;
  logic          new_dirty;
  logic          hash_diff;
  logic          room;

  assign load      = cmd_i.in_ready & in_valid_i;
  assign issue     = cmd_i.scan_run & (ptr_q < count_q);
  assign match     = cmp_v_q & (id_rd_q == rid_q);
  assign old_dirty = dirty_q[cmp_idx_q];
  assign hash_diff = hash_rd_q != rh_q;
  assign room      = count_q < PW'(MAX_ENTRIES);

  // Post-operation dirty mark of the entry under compare
  always_comb begin
    case (op_q)
      drct_pkg::OP_CONTENT:    new_dirty = match ? (old_dirty | hash_diff) : old_dirty;
      drct_pkg::OP_MARK_DIRTY: new_dirty = match | old_dirty;
      drct_pkg::OP_MARK_ALL:   new_dirty = 1'b1;
      drct_pkg::OP_MARK_CLEAN: new_dirty = match ? 1'b0 : old_dirty;
      default:                 new_dirty = old_dirty;
    endcase
  end

  // Capture request fields on transfer
  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q     <= in_op_i;
      rid_q    <= in_data_i[7:0];
      byte_q   <= in_data_i[15:8];
      bvalid_q <= in_data_i[16];
      last_q   <= in_last_i;
    end
  end

  // Table memories: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (issue) begin
      id_rd_q   <= ids_mem[ptr_q[IW-1:0]];
      hash_rd_q <= hash_mem[ptr_q[IW-1:0]];
    end
    if (cmd_i.finish && op_q == drct_pkg::OP_REGISTER && !found_q && room) begin
      ids_mem[count_q[IW-1:0]] <= rid_q;
    end
    if (cmd_i.finish && op_q == drct_pkg::OP_REGISTER && !found_q && room) begin
      hash_mem[count_q[IW-1:0]] <= '0;
    end else if (cmd_i.finish && op_q == drct_pkg::OP_CONTENT && found_q && chg_q) begin
      hash_mem[slot_q] <= rh_q;
    end
  end

  // Scan bookkeeping
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= ptr_q[IW-1:0];
    if (load) begin
      found_q <= 1'b0;
      slot_q  <= '0;
      chg_q   <= 1'b0;
    end else if (match) begin
      found_q <= 1'b1;
      slot_q  <= cmp_idx_q;
      chg_q   <= old_dirty | hash_diff;
    end
  end

  // Scan pointer, compare valid, mask accumulation, dirty marks, count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      cmp_v_q   <= 1'b0;
      dirty_q   <= '0;
      count_q   <= '0;
      mask_q    <= '0;
      any_q     <= 1'b0;
      changed_q <= 1'b0;
    end else begin
      cmp_v_q <= issue;
      if (load) begin
        ptr_q  <= '0;
        mask_q <= '0;
        any_q  <= 1'b0;
      end else if (issue) begin
        ptr_q <= ptr_q + PW'(1);
      end
      if (cmp_v_q) begin
        dirty_q[cmp_idx_q] <= new_dirty;
        if (new_dirty) begin
          any_q <= 1'b1;
          if (id_rd_q[7:4] == 4'd0) begin
            mask_q <= mask_q | (MW'(1) << id_rd_q[3:0]);
          end
        end
      end
      if (cmd_i.finish) begin
        changed_q <= (op_q == drct_pkg::OP_CONTENT) & (~found_q | chg_q);
        if (op_q == drct_pkg::OP_REGISTER && !found_q && room) begin
          dirty_q[count_q[IW-1:0]] <= 1'b1;
          count_q <= count_q + PW'(1);
          any_q   <= 1'b1;
          if (rid_q[7:4] == 4'd0) begin
            mask_q <= mask_q | (MW'(1) << rid_q[3:0]);
          end
        end
      end
    end
  end

  // Running hash and statistics counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rh_q      <= drct_pkg::FNV_BASIS;
      checks_q  <= '0;
      updates_q <= '0;
      skips_q   <= '0;
    end else begin
      if (cmd_i.hash_step && bvalid_q) begin
        rh_q <= 32'((rh_q ^ {24'd0, byte_q}) * drct_pkg::FNV_PRIME);
      end
      if (cmd_i.finish) begin
        case (op_q)
          drct_pkg::OP_CONTENT: begin
            checks_q <= checks_q + 32'd1;
            rh_q     <= drct_pkg::FNV_BASIS;
            if (!found_q || chg_q) begin
              updates_q <= updates_q + 32'd1;
            end else begin
              skips_q <= skips_q + 32'd1;
            end
          end
          drct_pkg::OP_RESET_STATS: begin
            checks_q  <= '0;
            updates_q <= '0;
            skips_q   <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Output register: hold until the receiver takes the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= {6'd0, skips_q, updates_q, checks_q, any_q, mask_q, changed_q};
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign sts_o.last      = last_q;
  assign sts_o.scan_done = (ptr_q >= count_q) & ~cmp_v_q;
  assign sts_o.out_free  = ~out_valid_q | out_ready_i;

endmodule

`default_nettype wire

/* src/dirty_region_change_tracker_top.sv */
// Dirty region change tracker.
// Input stream (s_axis): one operation per transfer. tuser carries the
// operation code, tlast ends a content check, tdata carries the region,
// content byte and byte-valid flag. Codes 6 and 7 are dropped silently.
// Output stream (m_axis): one result per register, mark, mark-all and
// reset-stats operation and per content item with tlast set.
// A content byte without tlast only steps the running hash. Every other
// answering operation, and the item that closes a check, scans the table
// one entry a cycle through its single read port, with the read data
// registered. One operation is in flight at a time; tready rises again
// once the result has been loaded into the output register.
// Reset empties the table, clears the dirty marks and the counters and
// returns the running hash to the FNV offset basis; no clearing pass runs.
// The result sits in an output register; when the receiver stalls, the
// block still takes the next operation, applies it to the table and the
// counters, and holds its result until the waiting one has been taken.
`default_nettype none

module dirty_region_change_tracker_top #(
  parameter int unsigned MAX_ENTRIES = drct_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [7:0] region, [15:8] data_byte, [16] byte_valid, [23:17] zero
  input  wire logic [drct_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // [2:0] operation
  input  wire logic [drct_pkg::IN_USER_W-1:0]   s_axis_tuser_i,
  input  wire logic                             s_axis_tlast_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // [0] changed, [16:1] dirty_mask, [17] any_dirty, [49:18] check_count,
  // [81:50] update_count, [113:82] skip_count, [119:114] zero
  output logic [drct_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o
);

  drct_pkg::cmd_t cmd;
  drct_pkg::sts_t sts;

  drct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_op_i    (s_axis_tuser_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  drct_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_valid_i  (s_axis_tvalid_i),
    .in_data_i   (s_axis_tdata_i),
    .in_op_i     (s_axis_tuser_i),
    .in_last_i   (s_axis_tlast_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o)
  );

  assign s_axis_tready_o = cmd.in_ready;

endmodule

`default_nettype wire

/* test/dirty_region_change_tracker_top_tb.sv */
`timescale 1ns / 1ps

module dirty_region_change_tracker_top_tb;
  import drct_pkg::*;

  localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;
  localparam int ITEM_TARGET = 1350;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 2 * (TABLE_DEPTH + 4);
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT = 300;
  localparam int STEADY_FROM = 700;
  localparam int STEADY_TO = 900;
  localparam int CONTENT_VARIANTS = 4;
  localparam int CONTENT_MAX = 6;
  localparam int DIRECTED_ROWS = 25;

  // Operation codes the block drops without answering
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // One answer, laid out as on m_axis_tdata (changed in bit 0)
  typedef struct packed {
    logic [31:0] skips;
    logic [31:0] updates;
    logic [31:0] checks;
    logic        any_dirty;
    logic [15:0] mask;
    logic        changed;
  } summary_t;

  // Directed step; the answer columns apply only where typed is set
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  id;
    logic [7:0]  data;
    logic        valid;
    logic        last;
    logic        typed;
    logic        changed;
    logic [15:0] mask;
    logic        any_dirty;
    logic [7:0]  checks;
    logic [7:0]  updates;
    logic [7:0]  skips;
  } step_row_t;

  // op, id, data, byte_valid, last, typed, changed, mask, any_dirty, checks, updates, skips
  step_row_t directed_steps [DIRECTED_ROWS] = '{
    '{OP_MARK_ALL,    8'd0,   8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_RESET_STATS, 8'd0,   8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_CONTENT,     8'd0,   8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b0, 8'd1, 8'd1, 8'd0},
    '{OP_REGISTER,    8'd0,   8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0001, 1'b1, 8'd1, 8'd1, 8'd0},
    '{OP_REGISTER,    8'd15,  8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 16'h8001, 1'b1, 8'd1, 8'd1, 8'd0},
    '{OP_REGISTER,    8'd255, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 16'h8001, 1'b1, 8'd1, 8'd1, 8'd0},
    '{OP_REGISTER,    8'd0,   8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 16'h8001, 1'b1, 8'd1, 8'd1, 8'd0},
    '{OP_MARK_CLEAN,  8'd0,   8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 16'h8000, 1'b1, 8'd1, 8'd1, 8'd0},
    '{OP_MARK_CLEAN,  8'd15,  8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b1, 8'd1, 8'd1, 8'd0},
    '{OP_MARK_CLEAN,  8'd255, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'd1, 8'd1, 8'd0},
    '{OP_MARK_DIRTY,  8'd77,  8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'd1, 8'd1, 8'd0},
    '{OP_MARK_CLEAN,  8'd200, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'd1, 8'd1, 8'd0},
    '{OP_CONTENT,     8'd0,   8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_SPARE_6,     8'h5A,  8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_MARK_DIRTY,  8'd15,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_CONTENT,     8'd0,   8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_SPARE_7,     8'hA5,  8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_CONTENT,     8'd0,   8'h01, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_MARK_CLEAN,  8'd0,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_CONTENT,     8'd0,   8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_CONTENT,     8'd0,   8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_CONTENT,     8'd0,   8'h01, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_CONTENT,     8'd0,   8'hAA, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_MARK_ALL,    8'd3,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_RESET_STATS, 8'd255, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 16'h8001, 1'b1, 8'd0, 8'd0, 8'd0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic [IN_USER_W-1:0]  s_axis_tuser_i;
  logic                  s_axis_tlast_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  // Tracker shadow state
  logic [7:0]  region_tags  [TABLE_DEPTH] = '{default: 8'd0};
  logic [31:0] region_hash  [TABLE_DEPTH] = '{default: 32'd0};
  logic        region_dirty [TABLE_DEPTH] = '{default: 1'b0};
  int          region_count = 0;
  logic [31:0] run_hash = FNV_BASIS;
  logic [31:0] check_cnt = 32'd0;
  logic [31:0] update_cnt = 32'd0;
  logic [31:0] skip_cnt = 32'd0;

  // Answers still owed by the block, oldest first
  summary_t expected_summaries [$];

  // Content strings reused across checks so that stored hashes match again
  logic [7:0] content_bytes [CONTENT_VARIANTS][CONTENT_MAX];
  int         content_len   [CONTENT_VARIANTS];

  int   ops_sent = 0;
  int   ignored_sent = 0;
  int   results_seen = 0;
  int   changed_total = 0;
  int   skipped_total = 0;
  int   mismatch_count = 0;
  int   cycle_count = 0;
  logic steady = 1'b0;
  logic hold_req = 1'b0;

  dirty_region_change_tracker_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int find_region(input logic [7:0] id);
    for (int k = 0; k < region_count; k++) begin
      if (region_tags[k] == id) return k;
    end
    return -1;
  endfunction

  // Apply one operation to the shadow table and form the answer it owes
  task automatic track_op(input logic [2:0] op, input logic [7:0] id, input logic [7:0] data,
                          input logic valid, input logic last,
                          output logic answers, output summary_t res);
    int   slot;
    logic changed;
    answers = 1'b1;
    changed = 1'b0;
    slot = find_region(id);
    case (op)
      OP_REGISTER: begin
        if (slot < 0 && region_count < TABLE_DEPTH) begin
          region_tags[region_count] = id;
          region_hash[region_count] = 32'd0;
          region_dirty[region_count] = 1'b1;
          region_count++;
        end
      end
      OP_CONTENT: begin
        if (valid) run_hash = (run_hash ^ {24'd0, data}) * FNV_PRIME;
        if (!last) begin
          answers = 1'b0;
        end else begin
          check_cnt++;
          changed = 1'b1;
          if (slot < 0) begin
            update_cnt++;
          end else if (run_hash != region_hash[slot] || region_dirty[slot]) begin
            region_hash[slot] = run_hash;
            region_dirty[slot] = 1'b1;
            update_cnt++;
          end else begin
            skip_cnt++;
            changed = 1'b0;
            skipped_total++;
          end
          if (changed) changed_total++;
          run_hash = FNV_BASIS;
        end
      end
      OP_MARK_DIRTY, OP_MARK_CLEAN: begin
        if (slot >= 0) region_dirty[slot] = (op == OP_MARK_DIRTY);
      end
      OP_MARK_ALL: begin
        for (int k = 0; k < region_count; k++) region_dirty[k] = 1'b1;
      end
      OP_RESET_STATS: begin
        check_cnt = 32'd0;
        update_cnt = 32'd0;
        skip_cnt = 32'd0;
      end
      default: answers = 1'b0;
    endcase
    res = '0;
    res.changed = changed;
    res.checks = check_cnt;
    res.updates = update_cnt;
    res.skips = skip_cnt;
    for (int k = 0; k < region_count; k++) begin
      if (region_dirty[k]) begin
        res.any_dirty = 1'b1;
        if (region_tags[k] < 8'd16) res.mask[region_tags[k][3:0]] = 1'b1;
      end
    end
  endtask

  // Offer one transfer from a falling edge, hold until taken, return at the next falling edge
  task automatic send_op(input logic [2:0] op, input logic [7:0] id, input logic [7:0] data,
                         input logic valid, input logic last,
                         input logic use_typed = 1'b0, input summary_t typed_res = '0);
    logic     answers;
    summary_t res;
    if (!steady && $urandom_range(99) < 20) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {7'd0, valid, data, id};
    s_axis_tuser_i <= op;
    s_axis_tlast_i <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    track_op(op, id, data, valid, last, answers, res);
    if (answers) expected_summaries.push_back(use_typed ? typed_res : res);
    if (op <= OP_RESET_STATS) ops_sent++;
    else ignored_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_region();
    case ($urandom_range(9))
      0: return 8'($urandom);
      1, 2: return 8'($urandom_range(255, 240));
      default: return 8'($urandom_range(15));
    endcase
  endfunction

  // Any single operation; a stray content byte only where a check may absorb it
  task automatic send_misc(input logic allow_content);
    int         roll;
    logic [7:0] id;
    roll = $urandom_range(99);
    id = pick_region();
    if (roll < 25) send_op(OP_REGISTER, id, 8'($urandom), 1'($urandom), 1'($urandom));
    else if (roll < 45) send_op(OP_MARK_DIRTY, id, 8'($urandom), 1'($urandom), 1'($urandom));
    else if (roll < 65) send_op(OP_MARK_CLEAN, id, 8'($urandom), 1'($urandom), 1'($urandom));
    else if (roll < 70) send_op(OP_MARK_ALL, id, 8'($urandom), 1'($urandom), 1'($urandom));
    else if (roll < 75) send_op(OP_RESET_STATS, id, 8'($urandom), 1'($urandom), 1'($urandom));
    else if (roll < 80) send_op(OP_SPARE_6, id, 8'($urandom), 1'($urandom), 1'($urandom));
    else if (roll < 85 || !allow_content)
      send_op(OP_SPARE_7, id, 8'($urandom), 1'($urandom), 1'($urandom));
    else send_op(OP_CONTENT, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0);
  endtask

  // Well-formed check of one region, now and then interrupted by other operations
  task automatic run_check(input logic [7:0] id);
    int   pick;
    int   len;
    logic trail;
    pick = $urandom_range(CONTENT_VARIANTS - 1);
    len = content_len[pick];
    trail = (len == 0) || ($urandom_range(99) < 15);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(99) < 8) send_misc(1'b0);
      if ($urandom_range(99) < 5) send_op(OP_CONTENT, 8'($urandom), 8'($urandom), 1'b0, 1'b0);
      send_op(OP_CONTENT, (k == len - 1) ? id : 8'($urandom), content_bytes[pick][k], 1'b1,
              (k == len - 1) && !trail);
    end
    if (trail) send_op(OP_CONTENT, id, 8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic void match_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare every answer with the oldest one owed
  always @(posedge clk_i) begin : result_monitor
    summary_t got;
    summary_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[$bits(summary_t)-1:0];
      results_seen++;
      if (expected_summaries.size() == 0) begin
        $error("unexpected result 0x%0h", got);
        mismatch_count++;
      end else begin
        want = expected_summaries.pop_front();
        match_field("changed", 32'(want.changed), 32'(got.changed));
        match_field("dirty_mask", 32'(want.mask), 32'(got.mask));
        match_field("any_dirty", 32'(want.any_dirty), 32'(got.any_dirty));
        match_field("check_count", want.checks, got.checks);
        match_field("update_count", want.updates, got.updates);
        match_field("skip_count", want.skips, got.skips);
      end
    end
  end

  // Receiver: random stalls, one long hold-off on request, none in the steady window
  initial begin : result_sink
    int   hold_left;
    logic hold_started;
    hold_left = 0;
    hold_started = 1'b0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_started) begin
        hold_left = HOLD_CYCLES;
        hold_started = 1'b1;
      end
      if (hold_left > 0) begin
        m_axis_tready_i <= 1'b0;
        hold_left--;
      end else if (steady) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= 20);
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    step_row_t  row;
    summary_t   typed_res;
    logic [7:0] region;
    logic       hold_done;
    hold_done = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = '0;
    s_axis_tlast_i = 1'b0;

    // Content variants; the first is the empty string
    for (int v = 0; v < CONTENT_VARIANTS; v++) begin
      content_len[v] = (v == 0) ? 0 : $urandom_range(CONTENT_MAX, 1);
      for (int k = 0; k < CONTENT_MAX; k++) content_bytes[v][k] = 8'($urandom);
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed steps
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = directed_steps[r];
      typed_res = '{skips: 32'(row.skips), updates: 32'(row.updates), checks: 32'(row.checks),
                    any_dirty: row.any_dirty, mask: row.mask, changed: row.changed};
      send_op(row.op, row.id, row.data, row.valid, row.last, row.typed, typed_res);
    end

    // Random traffic, mostly well-formed checks
    while (ops_sent < ITEM_TARGET) begin
      if (ops_sent >= HOLD_AT && !hold_done) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      steady = (ops_sent >= STEADY_FROM && ops_sent < STEADY_TO);
      if ($urandom_range(99) < 60) begin
        region = pick_region();
        if ($urandom_range(99) < 40)
          send_op(OP_MARK_CLEAN, region, 8'($urandom), 1'($urandom), 1'($urandom));
        run_check(region);
      end else begin
        send_misc(1'b1);
      end
    end
    steady = 1'b0;
    s_axis_tvalid_i <= 1'b0;

    // Drain outstanding answers, then let stray work settle
    while (expected_summaries.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d operations and %0d dropped codes; %0d answers compared in %0d cycles.",
             ops_sent, ignored_sent, results_seen, cycle_count);
    $display("Checks answered changed %0d times and skipped %0d times; %0d regions held.",
             changed_total, skipped_total, region_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
